// File: rtl/core/cicdi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cicdi_pkg
// Shared constants for the fourth-order I/Q CIC decimator core.
// ----------------------------------------------------------------------------
package cicdi_pkg;

  localparam int CIC_ORDER     = 4;   // integrator / comb sections per channel
  localparam int ACC_WIDTH_DEF = 56;  // default accumulator width
  localparam int SAMPLE_W      = 16;  // width of one I or Q sample
  localparam int TDATA_W       = 2 * SAMPLE_W;
  localparam int LOG2_W        = 4;   // width of the decimation register
  localparam int MAX_LOG2      = 10;  // largest usable decimation exponent
  localparam int PHASE_W       = 10;  // phase counter, modulo 2^MAX_LOG2
  localparam int SHIFT_W       = 6;   // holds 4 * MAX_LOG2
  localparam int EXT_W         = 64;  // width of the output shifter

endpackage

// File: rtl/core/cic_decimator_iq_order4_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cic_decimator_iq_order4_core
// Fourth-order CIC decimator, one I/Q sample per word, factor 2^decim_log2 (exponent capped at 10).
// ----------------------------------------------------------------------------
//
//  channel | direction | fields (tdata, low bit up)      | handshake
//  --------+-----------+---------------------------------+-----------------
//  in      | slave     | in_i[15:0], in_q[31:16]         | tvalid / tready
//  out     | master    | out_i[15:0], out_q[31:16]       | tvalid / tready
//  cfg     | write     | decim_log2[3:0]                 | cfg_we, no wait
//
//  one word per cycle sustained while out does not stall; each integrator and
//  each comb section is a pipeline stage of its own (one ACC_WIDTH-bit add
//  each, 56 bits by default); a word passes down the stages to the output register.
//  synchronous active-low reset clears all integrators, comb delays, the
//  phase counter, the register and the stage valid bits.
//  a stall on out only holds the pipeline when the last stage has a word
//  that cannot move on; otherwise every stage moves on, empty ones included.
//
module cic_decimator_iq_order4_core #(
  parameter int ACC_WIDTH = cicdi_pkg::ACC_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_we,
  input  logic [cicdi_pkg::LOG2_W-1:0] cfg_wdata,
  // input stream
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [cicdi_pkg::TDATA_W-1:0] in_tdata,   // in_i, in_q
  // result stream
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [cicdi_pkg::TDATA_W-1:0] out_tdata   // out_i, out_q
);

  localparam int ORD  = cicdi_pkg::CIC_ORDER;
  localparam int NSTG = 2 * ORD + 1;
  localparam int SW   = cicdi_pkg::SAMPLE_W;

  typedef struct packed {
    logic                          valid;
    logic                          bypass;
    logic                          fire;
    logic [cicdi_pkg::SHIFT_W-1:0] shift;
    logic [ACC_WIDTH-1:0]          di;
    logic [ACC_WIDTH-1:0]          dq;
  } stage_t;

  stage_t                        stg_r     [NSTG];
  stage_t                        stg_nxt   [NSTG];
  logic [ACC_WIDTH-1:0]          integ_i_r [ORD];
  logic [ACC_WIDTH-1:0]          integ_q_r [ORD];
  logic [ACC_WIDTH-1:0]          integ_i_nxt [ORD];
  logic [ACC_WIDTH-1:0]          integ_q_nxt [ORD];
  logic [ACC_WIDTH-1:0]          dly_i_r   [ORD];
  logic [ACC_WIDTH-1:0]          dly_q_r   [ORD];
  logic [ACC_WIDTH-1:0]          dly_i_nxt [ORD];
  logic [ACC_WIDTH-1:0]          dly_q_nxt [ORD];
  logic [cicdi_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [cicdi_pkg::LOG2_W-1:0]  decim_r, decim_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [cicdi_pkg::TDATA_W-1:0] out_data_r, out_data_nxt;

  logic [cicdi_pkg::LOG2_W-1:0]  eff_log2;
  logic [cicdi_pkg::PHASE_W-1:0] rmask;
  logic                          bypass;
  logic                          fire;
  logic                          adv;
  logic                          in_acc;
  logic signed [cicdi_pkg::EXT_W-1:0] ext_i, ext_q, sh_i, sh_q;

  // decimation exponents above the maximum act as the maximum
  assign eff_log2 = (decim_r > cicdi_pkg::LOG2_W'(cicdi_pkg::MAX_LOG2)) ?
                    cicdi_pkg::LOG2_W'(cicdi_pkg::MAX_LOG2) : decim_r;
  assign rmask    = ~({cicdi_pkg::PHASE_W{1'b1}} << eff_log2);
  assign bypass   = (eff_log2 == '0);
  assign fire     = ((phase_r & rmask) == '0);

  // hold only when the last stage has a word and the output is still full
  assign adv       = !(stg_r[NSTG-1].valid && out_valid_r && !out_tready);
  assign in_tready = adv;
  assign in_acc    = in_tvalid && adv;

  assign decim_nxt = cfg_we ? cfg_wdata : decim_r;

  always_comb begin
    stg_nxt     = stg_r;
    integ_i_nxt = integ_i_r;
    integ_q_nxt = integ_q_r;
    dly_i_nxt   = dly_i_r;
    dly_q_nxt   = dly_q_r;
    phase_nxt   = phase_r;
    if (adv) begin
      stg_nxt[0].valid  = in_acc;
      stg_nxt[0].bypass = bypass;
      stg_nxt[0].fire   = fire;
      stg_nxt[0].shift  = cicdi_pkg::SHIFT_W'({eff_log2, 2'b00});
      stg_nxt[0].di     = ACC_WIDTH'($signed(in_tdata[SW-1:0]));
      stg_nxt[0].dq     = ACC_WIDTH'($signed(in_tdata[2*SW-1:SW]));
      if (in_acc && !bypass) begin
        phase_nxt = (phase_r + 1'b1) & rmask;
      end

      for (int k = 0; k < NSTG - 1; k++) begin
        stg_nxt[k+1] = stg_r[k];
      end

      // integrator sections
      if (stg_r[0].valid && !stg_r[0].bypass) begin
        integ_i_nxt[0] = integ_i_r[0] + stg_r[0].di;
        integ_q_nxt[0] = integ_q_r[0] + stg_r[0].dq;
      end
      for (int k = 1; k < ORD; k++) begin
        if (stg_r[k].valid && !stg_r[k].bypass) begin
          integ_i_nxt[k] = integ_i_r[k] + integ_i_r[k-1];
          integ_q_nxt[k] = integ_q_r[k] + integ_q_r[k-1];
        end
      end

      // first comb section, words off the decimation phase drop out here
      stg_nxt[ORD+1].valid = stg_r[ORD].valid && (stg_r[ORD].bypass || stg_r[ORD].fire);
      if (stg_r[ORD].valid && !stg_r[ORD].bypass && stg_r[ORD].fire) begin
        stg_nxt[ORD+1].di = integ_i_r[ORD-1] - dly_i_r[0];
        stg_nxt[ORD+1].dq = integ_q_r[ORD-1] - dly_q_r[0];
        dly_i_nxt[0]      = integ_i_r[ORD-1];
        dly_q_nxt[0]      = integ_q_r[ORD-1];
      end
      for (int j = 1; j < ORD; j++) begin
        if (stg_r[ORD+j].valid && !stg_r[ORD+j].bypass) begin
          stg_nxt[ORD+j+1].di = stg_r[ORD+j].di - dly_i_r[j];
          stg_nxt[ORD+j+1].dq = stg_r[ORD+j].dq - dly_q_r[j];
          dly_i_nxt[j]        = stg_r[ORD+j].di;
          dly_q_nxt[j]        = stg_r[ORD+j].dq;
        end
      end
    end
  end

  // arithmetic shift of the comb result, shift is zero in bypass
  always_comb begin
    ext_i = cicdi_pkg::EXT_W'($signed(stg_r[NSTG-1].di));
    ext_q = cicdi_pkg::EXT_W'($signed(stg_r[NSTG-1].dq));
    sh_i  = ext_i >>> stg_r[NSTG-1].shift;
    sh_q  = ext_q >>> stg_r[NSTG-1].shift;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (!out_valid_r || out_tready) begin
      out_valid_nxt = stg_r[NSTG-1].valid;
      out_data_nxt  = {sh_q[SW-1:0], sh_i[SW-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NSTG; k++) begin
        stg_r[k] <= '0;
      end
      for (int k = 0; k < ORD; k++) begin
        integ_i_r[k] <= '0;
        integ_q_r[k] <= '0;
        dly_i_r[k]   <= '0;
        dly_q_r[k]   <= '0;
      end
      phase_r     <= '0;
      decim_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      stg_r       <= stg_nxt;
      integ_i_r   <= integ_i_nxt;
      integ_q_r   <= integ_q_nxt;
      dly_i_r     <= dly_i_nxt;
      dly_q_r     <= dly_q_nxt;
      phase_r     <= phase_nxt;
      decim_r     <= decim_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
